>>> hw/rtl/biquadratic_forward_splat_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the forward splat block
// Concurrent checks sampled on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BIQUADRATIC_FORWARD_SPLAT_TOP_ASSERT_SVH
`define BIQUADRATIC_FORWARD_SPLAT_TOP_ASSERT_SVH

// Same-cycle implication; the consequent may open with a fixed delay.
`define BQFS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("bqfs check failed");

// Next-cycle implication.
`define BQFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqfs check failed");

`endif

>>> hw/rtl/bqfs_pkg.sv
// ----------------------------------------------------------------------------
// bqfs_pkg
// Shared types, codes and fixed widths of the forward splat block.
// ----------------------------------------------------------------------------
`default_nettype none

package bqfs_pkg;

  // Item modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_SPLAT = 2'd0;
  localparam mode_t MODE_CLEAR = 2'd1;
  localparam mode_t MODE_READ  = 2'd2;
  localparam mode_t MODE_NOP   = 2'd3;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FLOW_SCALE = 3'd0;
  localparam cfg_idx_t CFG_DST_X0     = 3'd1;
  localparam cfg_idx_t CFG_DST_Y0     = 3'd2;
  localparam cfg_idx_t CFG_DST_W      = 3'd3;
  localparam cfg_idx_t CFG_DST_H      = 3'd4;

  typedef logic [15:0]        cfg_data_t;
  typedef logic [7:0]         coord_t;
  typedef logic [7:0]         pix_t;
  typedef logic signed [15:0] flow_t;
  typedef logic [31:0]        wsum_t;
  typedef logic [39:0]        wtot_t;

  // Shared multiplier
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    mul_op_t a;
    mul_op_t b;
  } mul_req_t;

  // Q.20 position and the integer target pixel taken from it
  localparam int POS_W = PROD_W + 1;
  localparam int FRAC  = 20;
  localparam int N_W   = POS_W - FRAC;

  typedef logic signed [15:0] off_t;  // Q1.15 sub-pixel offset
  typedef logic [15:0]        wt_t;   // Q1.15 weight, up to 1.0

endpackage

`default_nettype wire

>>> hw/rtl/bqfs_mul.sv
// ----------------------------------------------------------------------------
// bqfs_mul
// Shared signed 18x18 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bqfs_mul (
  input  logic              clk,
  input  bqfs_pkg::mul_req_t req,
  output bqfs_pkg::prod_t   prod
);
  import bqfs_pkg::*;

  prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> hw/rtl/biquadratic_forward_splat_top.sv
// ----------------------------------------------------------------------------
// biquadratic_forward_splat_top
// Forward-warp splatter with 3x3 quadratic weights into weight and total
// accumulator memories of IMG_DIM x IMG_DIM entries.
// ----------------------------------------------------------------------------
// Use:
//   in_*   : valid/ready item channel. mode selects splat, clear window, read.
//   out_*  : valid/ready result channel; only read items give a result.
//   cfg_*  : write channel for flow_scale, dst_x0, dst_y0, dst_w, dst_h;
//            always ready, write only while the block is idle.
// Sequence, per item (in_ready is low until the item is done):
//   read   : RD0 then RD1, then the result shows in the output register.
//   splat  : the item is dropped at the window check when the target lies
//            outside the window; else 9 set-up steps and 4 steps per cell, all
//            on one shared 18x18 multiplier, each cell a read-modify-write on
//            the simple dual-port accumulator pair.
//   clear  : writes zero across the window, one entry a cycle.
//   mode 3 : nothing happens.
// Reset: control and configuration registers take their reset values, then
//   a clearing pass writes zero to every entry, with in_ready low. Configuration
//   writes are taken during the pass.
// Stall: a result waits in the output register; a later read waits for it
//   to leave, other items carry on.
// ----------------------------------------------------------------------------
`default_nettype none

module biquadratic_forward_splat_top #(
  parameter int IMG_DIM = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bqfs_pkg::mode_t     in_mode,
  input  bqfs_pkg::coord_t    in_row,
  input  bqfs_pkg::coord_t    in_col,
  input  bqfs_pkg::pix_t      in_pixel_value,
  input  bqfs_pkg::flow_t     in_flow_x,
  input  bqfs_pkg::flow_t     in_flow_y,
  output logic                out_valid,
  input  logic                out_ready,
  output bqfs_pkg::wsum_t     out_weight_sum,
  output bqfs_pkg::wtot_t     out_weighted_total,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bqfs_pkg::cfg_idx_t  cfg_index,
  input  bqfs_pkg::cfg_data_t cfg_data
);
  import bqfs_pkg::*;

  localparam int CELLS = IMG_DIM * IMG_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(IMG_DIM);
  localparam int EW    = $clog2(IMG_DIM + 512) + 1;
  localparam int SW    = N_W + 1;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_CELL = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;
  localparam logic [2:0] ST_RD0  = 3'd5;
  localparam logic [2:0] ST_RD1  = 3'd6;

  // Control state
  logic [2:0]    state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [1:0]    ci_r, ci_nxt;
  logic [1:0]    cj_r, cj_nxt;
  logic [AW-1:0] init_r, init_nxt;
  logic [EW-1:0] cy_r, cy_nxt;
  logic [EW-1:0] cx_r, cx_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Configuration
  logic [15:0] fs_r;
  logic [7:0]  x0_r, y0_r;
  logic [8:0]  dst_w_r, dst_h_r;

  // Item and working registers
  coord_t              row_r, col_r;
  pix_t                val_r;
  flow_t               fx_r, fy_r;
  logic signed [N_W-1:0] ny_r, nx_r;
  off_t                ty_r, tx_r;
  wt_t                 wy_r [3];
  wt_t                 wx_r [3];
  wt_t                 cw_r;
  wsum_t               ows_r;
  wtot_t               owt_r;

  // Memories
  wsum_t wmem [CELLS];
  wtot_t tmem [CELLS];
  wsum_t rdw_r;
  wtot_t rdt_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  wsum_t         mem_wdw;
  wtot_t         mem_wdt;

  mul_req_t mreq;
  prod_t    prod;

  logic          accept, out_load;
  logic [EW-1:0] yend, xend, sum_y, sum_x;
  logic          win_nonempty, in_win;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] yc,
                                            input logic [CW-1:0] xc);
    addr_of = AW'(yc) * AW'(IMG_DIM) + AW'(xc);
  endfunction

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_RD1) && (!out_valid_r || out_ready);

  // Window ends, clipped to the image
  always_comb begin
    sum_y = EW'(y0_r) + EW'(dst_h_r);
    sum_x = EW'(x0_r) + EW'(dst_w_r);
    yend  = (sum_y > EW'(IMG_DIM)) ? EW'(IMG_DIM) : sum_y;
    xend  = (sum_x > EW'(IMG_DIM)) ? EW'(IMG_DIM) : sum_x;
    win_nonempty = (EW'(y0_r) < yend) && (EW'(x0_r) < xend);
  end

  // Target and offset from the product of flow_scale and flow
  coord_t                coord_sel;
  logic signed [POS_W-1:0] pos, pos_rnd;
  logic signed [20:0]    d_loc, dt_loc;
  logic signed [N_W-1:0] n_loc;
  off_t                  t_loc;

  always_comb begin
    coord_sel = (step_r == 4'd1) ? row_r : col_r;
    pos       = $signed({{(POS_W-28){1'b0}}, coord_sel, 20'd0}) - $signed({prod[PROD_W-1], prod});
    pos_rnd   = pos + $signed(POS_W'(524288));
    n_loc     = pos_rnd[POS_W-1:FRAC];
    d_loc     = $signed({1'b0, pos_rnd[FRAC-1:0]}) - 21'sd524288;
    dt_loc    = d_loc + 21'sd16;
    t_loc     = dt_loc[20:5];
  end

  // Axis weight operands and rounded products
  off_t          t_sel, t_abs;
  mul_op_t       op_t, op_abs, op_minus, op_plus;
  prod_t         rnd15, rnd16, rnd7;
  wt_t           w_center, w_side, w_cell, t_inc;

  always_comb begin
    t_sel    = (step_r < 4'd5) ? ty_r : tx_r;
    t_abs    = t_sel[15] ? -t_sel : t_sel;
    op_t     = {{2{t_sel[15]}}, t_sel};
    op_abs   = {2'b00, t_abs};
    op_minus = 18'sd32768 - op_t;
    op_plus  = 18'sd32768 + op_t;
    rnd15    = prod + 36'sd16384;
    rnd16    = prod + 36'sd32768;
    rnd7     = prod + 36'sd64;
    w_cell   = rnd15[30:15];
    w_center = 16'd32768 - rnd15[30:15];
    w_side   = rnd16[31:16];
    t_inc    = rnd7[22:7];
  end

  // Acceptance: target strictly inside, all nine cells within the window
  logic signed [SW-1:0] ny_s, nx_s, y0_s, x0_s, ye_s, xe_s;

  always_comb begin
    ny_s   = {ny_r[N_W-1], ny_r};
    nx_s   = {nx_r[N_W-1], nx_r};
    y0_s   = $signed(SW'(y0_r));
    x0_s   = $signed(SW'(x0_r));
    ye_s   = $signed(SW'(yend));
    xe_s   = $signed(SW'(xend));
    in_win = (ny_s > y0_s) && (ny_s + $signed(SW'(1)) < ye_s) &&
             (nx_s > x0_s) && (nx_s + $signed(SW'(1)) < xe_s);
  end

  // Cell address
  logic signed [N_W-1:0] ycell_s, xcell_s;
  logic [AW-1:0]         cell_addr, item_addr, clr_addr;
  logic                  item_oob;

  always_comb begin
    ycell_s   = ny_r - N_W'(1) + $signed({{(N_W-2){1'b0}}, ci_r});
    xcell_s   = nx_r - N_W'(1) + $signed({{(N_W-2){1'b0}}, cj_r});
    cell_addr = addr_of(ycell_s[CW-1:0], xcell_s[CW-1:0]);
    item_addr = addr_of(CW'(row_r), CW'(col_r));
    clr_addr  = addr_of(CW'(cy_r), CW'(cx_r));
    item_oob  = (32'(row_r) >= 32'(IMG_DIM)) || (32'(col_r) >= 32'(IMG_DIM));
  end

  // Multiplier operand selection
  always_comb begin
    mreq = '0;
    if (state_r == ST_CALC) begin
      case (step_r)
        4'd0: begin
          mreq.a = {2'b00, fs_r};
          mreq.b = {{2{fy_r[15]}}, fy_r};
        end
        4'd1: begin
          mreq.a = {2'b00, fs_r};
          mreq.b = {{2{fx_r[15]}}, fx_r};
        end
        4'd2, 4'd5: begin
          mreq.a = op_t;
          mreq.b = op_t;
        end
        4'd3, 4'd6: begin
          mreq.a = op_minus;
          mreq.b = op_abs;
        end
        4'd4, 4'd7: begin
          mreq.a = op_plus;
          mreq.b = op_abs;
        end
        default: mreq = '0;
      endcase
    end else if (state_r == ST_CELL) begin
      if (ph_r == 2'd0) begin
        mreq.a = {2'b00, wy_r[ci_r]};
        mreq.b = {2'b00, wx_r[cj_r]};
      end else if (ph_r == 2'd2) begin
        mreq.a = {2'b00, cw_r};
        mreq.b = {10'd0, val_r};
      end
    end
  end

  bqfs_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // Memory port control, saturating update of one cell
  logic [32:0] ws_add;
  logic [40:0] ts_add;

  always_comb begin
    ws_add    = {1'b0, rdw_r} + 33'({cw_r, 1'b0});
    ts_add    = {1'b0, rdt_r} + 41'(t_inc);
    mem_we    = 1'b0;
    mem_waddr = init_r;
    mem_wdw   = '0;
    mem_wdt   = '0;
    mem_raddr = item_addr;
    unique case (state_r)
      ST_INIT: mem_we = 1'b1;
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_CELL: begin
        mem_raddr = cell_addr;
        mem_waddr = cell_addr;
        mem_we    = (ph_r == 2'd3);
        mem_wdw   = ws_add[32] ? '1 : ws_add[31:0];
        mem_wdt   = ts_add[40] ? '1 : ts_add[39:0];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[mem_waddr] <= mem_wdw;
      tmem[mem_waddr] <= mem_wdt;
    end
    rdw_r <= wmem[mem_raddr];
    rdt_r <= tmem[mem_raddr];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ph_nxt        = ph_r;
    ci_nxt        = ci_r;
    cj_nxt        = cj_r;
    init_nxt      = init_r;
    cy_nxt        = cy_r;
    cx_nxt        = cx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_INIT: begin
        init_nxt = init_r + AW'(1);
        if (init_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_SPLAT: begin
              state_nxt = ST_CALC;
              step_nxt  = 4'd0;
            end
            MODE_CLEAR: begin
              if (win_nonempty) begin
                state_nxt = ST_CLR;
                cy_nxt    = EW'(y0_r);
                cx_nxt    = EW'(x0_r);
              end
            end
            MODE_READ: state_nxt = ST_RD0;
            MODE_NOP:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        step_nxt = step_r + 4'd1;
        // drop the item once the target is known to miss the window
        if (step_r == 4'd3 && !in_win) begin
          state_nxt = ST_IDLE;
        end else if (step_r == 4'd8) begin
          state_nxt = ST_CELL;
          ph_nxt    = 2'd0;
          ci_nxt    = 2'd0;
          cj_nxt    = 2'd0;
        end
      end
      ST_CELL: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          if (cj_r == 2'd2) begin
            cj_nxt = 2'd0;
            if (ci_r == 2'd2) begin
              state_nxt = ST_IDLE;
            end else begin
              ci_nxt = ci_r + 2'd1;
            end
          end else begin
            cj_nxt = cj_r + 2'd1;
          end
        end
      end
      ST_CLR: begin
        if (cx_r == xend - EW'(1)) begin
          cx_nxt = EW'(x0_r);
          if (cy_r == yend - EW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            cy_nxt = cy_r + EW'(1);
          end
        end else begin
          cx_nxt = cx_r + EW'(1);
        end
      end
      ST_RD0: state_nxt = ST_RD1;
      ST_RD1: begin
        // hold until the output register is free
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      step_r      <= '0;
      ph_r        <= '0;
      ci_r        <= '0;
      cj_r        <= '0;
      init_r      <= '0;
      cy_r        <= '0;
      cx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ph_r        <= ph_nxt;
      ci_r        <= ci_nxt;
      cj_r        <= cj_nxt;
      init_r      <= init_nxt;
      cy_r        <= cy_nxt;
      cx_r        <= cx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r    <= 16'd4096;
      x0_r    <= '0;
      y0_r    <= '0;
      dst_w_r <= 9'd256;
      dst_h_r <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FLOW_SCALE: fs_r    <= cfg_data;
        CFG_DST_X0:     x0_r    <= cfg_data[7:0];
        CFG_DST_Y0:     y0_r    <= cfg_data[7:0];
        CFG_DST_W:      dst_w_r <= cfg_data[8:0];
        CFG_DST_H:      dst_h_r <= cfg_data[8:0];
        default:        fs_r    <= fs_r;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= in_row;
      col_r <= in_col;
      val_r <= in_pixel_value;
      fx_r  <= in_flow_x;
      fy_r  <= in_flow_y;
    end
    if (state_r == ST_CALC) begin
      case (step_r)
        4'd1: begin
          ny_r <= n_loc;
          ty_r <= t_loc;
        end
        4'd2: begin
          nx_r <= n_loc;
          tx_r <= t_loc;
        end
        4'd3: wy_r[1] <= w_center;
        4'd4: wy_r[0] <= w_side;
        4'd5: wy_r[2] <= w_side;
        4'd6: wx_r[1] <= w_center;
        4'd7: wx_r[0] <= w_side;
        4'd8: wx_r[2] <= w_side;
        default: cw_r <= cw_r;
      endcase
    end
    if (state_r == ST_CELL && ph_r == 2'd1) begin
      cw_r <= w_cell;
    end
    if (out_load) begin
      ows_r <= item_oob ? '0 : rdw_r;
      owt_r <= item_oob ? '0 : rdt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_weight_sum     = ows_r;
  assign out_weighted_total = owt_r;

endmodule

`default_nettype wire

>>> hw/rtl/bqfs_chk.sv
// ----------------------------------------------------------------------------
// bqfs_chk
// Port-level checks on the forward splat block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "biquadratic_forward_splat_top_assert.svh"

module bqfs_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input bqfs_pkg::mode_t     in_mode,
  input logic                out_valid,
  input logic                out_ready,
  input bqfs_pkg::wsum_t     out_weight_sum,
  input bqfs_pkg::wtot_t     out_weighted_total,
  input logic                cfg_valid,
  input logic                cfg_ready
);
  import bqfs_pkg::*;

  // a stalled result holds
  `BQFS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_weight_sum) && $stable(out_weighted_total))

  // splat and read items keep the block busy for at least the next cycle
  `BQFS_ASSERT_NXT(a_busy_after_item, in_valid && in_ready && (in_mode == MODE_SPLAT || in_mode == MODE_READ), !in_ready)

  // a read into a free output register shows its result once RD1 loads it
  `BQFS_ASSERT_NOW(a_read_result, in_valid && in_ready && in_mode == MODE_READ && !out_valid, ##3 out_valid)

  // configuration writes are never stalled
  `BQFS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind biquadratic_forward_splat_top bqfs_chk u_bqfs_chk (.*);

`default_nettype wire
